### rtl/ppl_pkg.sv
// Shared constants and types for the polyline path length block.
package ppl_pkg;

	localparam int COORD_BITS  = 16;
	localparam int FRAC_BITS   = 8;
	localparam int TOL_BITS    = 16;
	localparam int SUM_BITS    = 40;
	localparam int DIFF_BITS   = COORD_BITS;
	localparam int SQ_BITS     = 2 * DIFF_BITS;
	localparam int ROOT_BITS   = (SQ_BITS + 1 + 2 * FRAC_BITS + 1) / 2;
	localparam int RAD_BITS    = 2 * ROOT_BITS;
	localparam int REM_BITS    = ROOT_BITS + 2;
	localparam int CNT_BITS    = $clog2(ROOT_BITS);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

	typedef struct packed {
		logic [DIFF_BITS-1:0] adx;
		logic [DIFF_BITS-1:0] ady;
		logic                 add_seg;
		logic                 last;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SQX,
		BK_SQY,
		BK_ADD,
		BK_ROOT,
		BK_ACC
	} back_state_t;

endpackage

### rtl/ppl_front.sv
// Front end: vertex intake, coordinate differences and backtrack detection.
module ppl_front
	import ppl_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic                         last_vertex,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [TOL_BITS-1:0]          cfg_data,
	input  q_status_t                    q_status,
	output logic                         push,
	output job_t                         push_job
);

	logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q, older_x_q, older_y_q;
	logic [1:0]                   seen_q;
	logic [TOL_BITS-1:0]          tol_q;
	logic signed [COORD_BITS:0]   dpx, dpy, dox, doy;
	logic [DIFF_BITS-1:0]         apx, apy, aox, aoy;
	logic                         match_x, match_y, backtrack;

	assign in_stall  = q_status.full;
	assign cfg_ready = 1'b1;
	assign push      = in_valid && !q_status.full;

	always_comb begin
		dpx = {prev_x_q[COORD_BITS-1], prev_x_q} - {x_coord[COORD_BITS-1], x_coord};
		dpy = {prev_y_q[COORD_BITS-1], prev_y_q} - {y_coord[COORD_BITS-1], y_coord};
		dox = {older_x_q[COORD_BITS-1], older_x_q} - {x_coord[COORD_BITS-1], x_coord};
		doy = {older_y_q[COORD_BITS-1], older_y_q} - {y_coord[COORD_BITS-1], y_coord};
		apx = dpx[COORD_BITS] ? DIFF_BITS'(-dpx) : DIFF_BITS'(dpx);
		apy = dpy[COORD_BITS] ? DIFF_BITS'(-dpy) : DIFF_BITS'(dpy);
		aox = dox[COORD_BITS] ? DIFF_BITS'(-dox) : DIFF_BITS'(dox);
		aoy = doy[COORD_BITS] ? DIFF_BITS'(-doy) : DIFF_BITS'(doy);
		match_x = {{TOL_BITS{1'b0}}, aox} <= {{DIFF_BITS{1'b0}}, tol_q};
		match_y = {{TOL_BITS{1'b0}}, aoy} <= {{DIFF_BITS{1'b0}}, tol_q};
		backtrack = (seen_q == 2'd2) && match_x && match_y;
		push_job.adx     = apx;
		push_job.ady     = apy;
		push_job.add_seg = (seen_q != 2'd0) && !backtrack;
		push_job.last    = last_vertex;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			tol_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			older_x_q <= '0;
			older_y_q <= '0;
			seen_q    <= '0;
		end else if (push) begin
			if (last_vertex) begin
				prev_x_q  <= '0;
				prev_y_q  <= '0;
				older_x_q <= '0;
				older_y_q <= '0;
				seen_q    <= '0;
			end else begin
				older_x_q <= prev_x_q;
				older_y_q <= prev_y_q;
				prev_x_q  <= x_coord;
				prev_y_q  <= y_coord;
				if (seen_q != 2'd2) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

endmodule

### rtl/ppl_fifo.sv
// Short job queue between the front end and the length engine.
module ppl_fifo
	import ppl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      pop_job,
	output q_status_t q_status
);

	job_t                 mem [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign pop_job        = mem[rd_ptr_q];
	assign q_status.full  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_status.full)) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_status.empty)) else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_BITS+1)'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

### rtl/ppl_back.sv
// Length engine: squares, bit-serial square root, saturating sum, result register.
module ppl_back
	import ppl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  q_status_t           q_status,
	input  job_t                pop_job,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SUM_BITS-1:0] path_length,
	output logic                overflow
);

	back_state_t          state_q, state_d;
	job_t                 job_q;
	logic [SQ_BITS-1:0]   sqx_q, sqy_q;
	logic [RAD_BITS-1:0]  rad_q;
	logic [REM_BITS-1:0]  rem_q, rem_shift, trial;
	logic [ROOT_BITS-1:0] root_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [SUM_BITS-1:0]  sum_q, path_length_q;
	logic                 sat_q, out_valid_q, overflow_q;
	logic [SUM_BITS:0]    acc_sum;
	logic                 out_free, acc_go, root_done, take_bit;

	assign out_valid   = out_valid_q;
	assign path_length = path_length_q;
	assign overflow    = overflow_q;
	assign out_free    = !out_valid_q || !out_stall;

	always_comb begin
		rem_shift = {rem_q[REM_BITS-3:0], rad_q[RAD_BITS-1 -: 2]};
		trial     = {root_q, 2'b01};
		take_bit  = rem_shift >= trial;
		acc_sum   = {1'b0, sum_q} + (SUM_BITS+1)'(root_q);
		root_done = (cnt_q == CNT_BITS'(ROOT_BITS - 1));
	end

	always_comb begin
		pop    = 1'b0;
		acc_go = 1'b0;
		unique case (state_q)
			BK_IDLE: pop    = !q_status.empty;
			BK_ACC:  acc_go = !job_q.last || out_free;
			default: begin
				pop    = 1'b0;
				acc_go = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty) begin
					state_d = pop_job.add_seg ? BK_SQX : BK_ACC;
				end
			end
			BK_SQX:  state_d = BK_SQY;
			BK_SQY:  state_d = BK_ADD;
			BK_ADD:  state_d = BK_ROOT;
			BK_ROOT: begin
				if (root_done) begin
					state_d = BK_ACC;
				end
			end
			BK_ACC: begin
				if (acc_go) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= pop_job;
			root_q <= '0;
		end
		if (state_q == BK_SQX) begin
			sqx_q <= job_q.adx * job_q.adx;
		end
		if (state_q == BK_SQY) begin
			sqy_q <= job_q.ady * job_q.ady;
		end
		if (state_q == BK_ADD) begin
			rad_q <= RAD_BITS'({1'b0, sqx_q} + {1'b0, sqy_q}) << (2 * FRAC_BITS);
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (state_q == BK_ROOT) begin
			rad_q <= rad_q << 2;
			cnt_q <= cnt_q + 1'b1;
			if (take_bit) begin
				rem_q  <= rem_shift - trial;
				root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= rem_shift;
				root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
			end
		end
		if (acc_go && job_q.last) begin
			path_length_q <= acc_sum[SUM_BITS] ? SUM_MAX : acc_sum[SUM_BITS-1:0];
			overflow_q    <= sat_q || acc_sum[SUM_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_go && job_q.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (acc_go) begin
				if (job_q.last) begin
					sum_q <= '0;
					sat_q <= 1'b0;
				end else if (acc_sum[SUM_BITS]) begin
					sum_q <= SUM_MAX;
					sat_q <= 1'b1;
				end else begin
					sum_q <= acc_sum[SUM_BITS-1:0];
				end
			end
		end
	end

	a_sat_pins_max: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> (sum_q == SUM_MAX)) else $error("saturated sum below maximum");
	a_root_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_ROOT) |-> (cnt_q < CNT_BITS'(ROOT_BITS))) else $error("root count overrun");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_ACC && job_q.last && out_valid_q && out_stall) |=> (state_q == BK_ACC))
		else $error("result overwrote a waiting beat");

endmodule

### rtl/polyline_path_length.sv
// Top level of the polyline path length block.
//
//  channel  dir  handshake            payload
//  in       in   in_valid/in_stall    x_coord, y_coord, last_vertex
//  out      out  out_valid/out_stall  path_length, overflow
//  cfg      in   cfg_valid/cfg_ready  cfg_data (match tolerance)
//
// A vertex that adds a segment passes through the length engine in order: fetch, the two
// squares and their sum, the bit-serial square root, then accumulate. A vertex that adds
// no segment goes from fetch straight to accumulate.
// The front end accepts vertices ahead of the engine until the four-entry queue fills.
// Reset clears the path state, the tolerance and the result valid flag; a stalled
// result beat holds the engine at its accumulate step.
module polyline_path_length
	import ppl_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic                         last_vertex,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [SUM_BITS-1:0]          path_length,
	output logic                         overflow,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [TOL_BITS-1:0]          cfg_data
);

	q_status_t q_status;
	logic      push, pop;
	job_t      push_job, pop_job;

	ppl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.last_vertex (last_vertex),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.q_status    (q_status),
		.push        (push),
		.push_job    (push_job)
	);

	ppl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.q_status (q_status)
	);

	ppl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.pop_job     (pop_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.path_length (path_length),
		.overflow    (overflow)
	);

endmodule
